@@ sv/tss_pkg.sv @@
// shared types and constants of the tick scheduler
package tss_pkg;

  localparam int NUM_TASKS = 6;
  localparam int NUM_SEMS  = 4;
  localparam int TASK_W    = 3;
  localparam int SEM_W     = 2;
  localparam int TICK_W    = 8;
  localparam int SLEEP_W   = 16;
  localparam int CNT_W     = 5;
  localparam int QLEN_W    = 3;
  localparam int PRIO_W    = 48;
  localparam int SEMINIT_W = 16;

  localparam logic signed [CNT_W-1:0] CNT_MIN = -5'sd16;
  localparam logic signed [CNT_W-1:0] CNT_MAX = 5'sd15;
  localparam logic [PRIO_W-1:0]    PRIO_RESET    = 48'h0101_0101_0101;
  localparam logic [SEMINIT_W-1:0] SEMINIT_RESET = 16'h3111;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_SLEEP  = 3'd1,
    MODE_P      = 3'd2,
    MODE_V      = 3'd3,
    MODE_REINIT = 3'd4
  } tss_mode_e;

  typedef enum logic {
    REG_PRIO    = 1'b0,
    REG_SEMINIT = 1'b1
  } tss_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_DEC, ST_PICK, ST_REFILL, ST_PICK2, ST_OUT
  } tss_state_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic [SEM_W-1:0]   sem_id;
    logic [SLEEP_W-1:0] sleep_ticks;
  } tss_item_t;

  typedef struct packed {
    logic [TASK_W-1:0] current_task;
    logic              none_ready;
    logic              caller_blocked;
    logic              woken_valid;
    logic [TASK_W-1:0] woken_task;
  } tss_result_t;

  typedef struct packed {
    logic              index;
    logic [PRIO_W-1:0] data;
  } tss_cfg_t;

  typedef struct packed {
    logic               dec_sleep;
    logic               refill;
    logic               tick_dec;
    logic               set_sleep;
    logic [SLEEP_W-1:0] sleep_val;
    logic               set_wait;
    logic               clr_wait;
  } tss_cell_cmd_t;

  typedef struct packed {
    logic [TICK_W-1:0] most;
    logic [TASK_W-1:0] idx;
  } tss_best_t;

endpackage

@@ sv/tss_stream_if.sv @@
// valid/ready channel carrying one payload beat
interface tss_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/tick_scheduler_with_semaphores.sv @@
// tick scheduler top: sequencer, semaphore state and the row of task cells
// sequence: V, P without blocking and reinit go from exec straight to output;
//   a reschedule walks exec, sleep decrement and pick chain, and ticks reload
//   with a second pick when the first pick finds no task
// one item at a time: a new item is taken only in idle, after the result is loaded
// reset: all task state and queue lengths clear, counts load 1,1,1,3
module tick_scheduler_with_semaphores (
  input  logic clk_i,
  input  logic rst_ni,
  tss_stream_if.sink   in_i,
  tss_stream_if.source out_o,
  tss_stream_if.sink   cfg_i
);
  import tss_pkg::*;

  tss_state_e state_q, state_d;
  tss_item_t  item_q;
  logic [TASK_W-1:0]    run_q;
  logic [PRIO_W-1:0]    prio_q;
  logic [SEMINIT_W-1:0] seminit_q;
  logic signed [CNT_W-1:0] cnt_q [NUM_SEMS];
  logic [QLEN_W-1:0]    len_q [NUM_SEMS];
  logic [TASK_W-1:0]    queue_q [NUM_SEMS][NUM_TASKS];
  logic none_q, blocked_q, woke_q;
  logic [TASK_W-1:0] woken_q;
  logic        out_valid_q;
  tss_result_t out_q;

  // decoded item
  logic [SEM_W-1:0] sid;
  logic signed [CNT_W-1:0] cnt_cur, cnt_p, cnt_v;
  logic is_tick, is_sleep, is_p, is_v, is_reinit;
  logic p_blocks, v_wakes, resched;
  logic [TASK_W-1:0] head;

  tss_cell_cmd_t cmd [NUM_TASKS];
  tss_best_t     chain [NUM_TASKS+1];
  logic          found;
  logic          out_load;

  assign sid       = item_q.sem_id;
  assign cnt_cur   = cnt_q[sid];
  assign cnt_p     = (cnt_cur != CNT_MIN) ? cnt_cur - 5'sd1 : cnt_cur;
  assign cnt_v     = (cnt_cur != CNT_MAX) ? cnt_cur + 5'sd1 : cnt_cur;
  assign is_tick   = item_q.mode == MODE_TICK;
  assign is_sleep  = item_q.mode == MODE_SLEEP;
  assign is_p      = item_q.mode == MODE_P;
  assign is_v      = item_q.mode == MODE_V;
  assign is_reinit = item_q.mode == MODE_REINIT;
  assign p_blocks  = cnt_p < 5'sd0;
  assign v_wakes   = (cnt_v <= 5'sd0) && (len_q[sid] != '0);
  assign head      = queue_q[sid][0];
  assign resched   = is_tick || is_sleep || (is_p && p_blocks);

  // pick chain: each cell passes the best candidate so far to its right
  assign chain[0] = '0;
  assign found    = chain[NUM_TASKS].most != '0;

  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    tss_task_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (TASK_W'(i)),
      .prio_i (prio_q[TICK_W*i +: TICK_W]),
      .cmd_i  (cmd[i]),
      .best_i (chain[i]),
      .best_o (chain[i+1])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_i.valid) state_d = ST_EXEC;
      ST_EXEC:   state_d = resched ? ST_DEC : ST_OUT;
      ST_DEC:    state_d = ST_PICK;
      ST_PICK:   state_d = found ? ST_OUT : ST_REFILL;
      ST_REFILL: state_d = ST_PICK2;
      ST_PICK2:  state_d = ST_OUT;
      ST_OUT:    if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // state outputs: cell commands and handshakes
  always_comb begin
    for (int i = 0; i < NUM_TASKS; i++) begin
      cmd[i]           = '0;
      cmd[i].sleep_val = item_q.sleep_ticks;
      cmd[i].dec_sleep = state_q == ST_DEC;
      cmd[i].refill    = state_q == ST_REFILL;
      if (state_q == ST_EXEC && run_q == TASK_W'(i)) begin
        cmd[i].tick_dec  = is_tick;
        cmd[i].set_sleep = is_sleep;
        cmd[i].set_wait  = is_p && p_blocks;
      end
      if (state_q == ST_EXEC && is_v && v_wakes && head == TASK_W'(i)) begin
        cmd[i].clr_wait = 1'b1;
      end
    end
  end

  assign in_i.ready  = state_q == ST_IDLE;
  assign cfg_i.ready = 1'b1;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= '0;
      prio_q      <= PRIO_RESET;
      seminit_q   <= SEMINIT_RESET;
      out_valid_q <= 1'b0;
      none_q      <= 1'b0;
      blocked_q   <= 1'b0;
      woke_q      <= 1'b0;
      woken_q     <= '0;
      for (int s = 0; s < NUM_SEMS; s++) begin
        cnt_q[s] <= CNT_W'({1'b0, SEMINIT_RESET[4*s +: 4]});
        len_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;
      // configuration beats
      if (cfg_i.valid) begin
        unique case (tss_reg_e'(cfg_i.payload.index))
          REG_PRIO:    prio_q    <= cfg_i.payload.data;
          REG_SEMINIT: seminit_q <= cfg_i.payload.data[SEMINIT_W-1:0];
          default:     ;
        endcase
      end
      if (state_q == ST_IDLE && in_i.valid) begin
        none_q    <= 1'b0;
        blocked_q <= 1'b0;
        woke_q    <= 1'b0;
        woken_q   <= '0;
      end
      // semaphore side of the item
      if (state_q == ST_EXEC) begin
        if (is_p) begin
          cnt_q[sid] <= cnt_p;
          if (p_blocks) begin
            blocked_q <= 1'b1;
            if (len_q[sid] < QLEN_W'(NUM_TASKS)) begin
              len_q[sid] <= len_q[sid] + 1'b1;
            end
          end
        end
        if (is_v) begin
          cnt_q[sid] <= cnt_v;
          if (v_wakes) begin
            woke_q     <= 1'b1;
            woken_q    <= head;
            len_q[sid] <= len_q[sid] - 1'b1;
          end
        end
        if (is_reinit) begin
          for (int s = 0; s < NUM_SEMS; s++) begin
            cnt_q[s] <= CNT_W'({1'b0, seminit_q[4*s +: 4]});
          end
        end
      end
      if ((state_q == ST_PICK || state_q == ST_PICK2) && found) begin
        run_q <= chain[NUM_TASKS].idx;
      end
      if (state_q == ST_PICK2 && !found) begin
        none_q <= 1'b1;
      end
      // output register
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers: item, queues, result beat
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_i.valid) begin
      item_q <= in_i.payload;
    end
    if (state_q == ST_EXEC) begin
      if (is_p && p_blocks && len_q[sid] < QLEN_W'(NUM_TASKS)) begin
        queue_q[sid][len_q[sid]] <= run_q;
      end
      if (is_v && v_wakes) begin
        for (int k = 0; k < NUM_TASKS - 1; k++) begin
          queue_q[sid][k] <= queue_q[sid][k+1];
        end
      end
    end
    if (out_load) begin
      out_q.current_task   <= run_q;
      out_q.none_ready     <= none_q;
      out_q.caller_blocked <= blocked_q;
      out_q.woken_valid    <= woke_q;
      out_q.woken_task     <= woken_q;
    end
  end
endmodule

@@ sv/tss_task_cell.sv @@
// one task cell: ticks, sleep counter, waiting flag and a link of the pick chain
module tss_task_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tss_pkg::TASK_W-1:0] idx_i,
  input  logic [tss_pkg::TICK_W-1:0] prio_i,
  input  tss_pkg::tss_cell_cmd_t     cmd_i,
  input  tss_pkg::tss_best_t         best_i,
  output tss_pkg::tss_best_t         best_o
);
  import tss_pkg::*;

  logic [TICK_W-1:0]  ticks_q, ticks_d;
  logic [SLEEP_W-1:0] sleep_q, sleep_d;
  logic               wait_q, wait_d;
  logic               eligible;

  assign eligible = !wait_q && (sleep_q == '0);

  always_comb begin
    ticks_d = ticks_q;
    if (cmd_i.refill && eligible) begin
      ticks_d = prio_i;
    end else if (cmd_i.tick_dec && ticks_q != '0) begin
      ticks_d = ticks_q - 1'b1;
    end
    sleep_d = sleep_q;
    if (cmd_i.set_sleep) begin
      sleep_d = cmd_i.sleep_val;
    end else if (cmd_i.dec_sleep && sleep_q != '0) begin
      sleep_d = sleep_q - 1'b1;
    end
    wait_d = wait_q;
    if (cmd_i.set_wait) begin
      wait_d = 1'b1;
    end else if (cmd_i.clr_wait) begin
      wait_d = 1'b0;
    end
  end

  // strict compare keeps the lower index on ties
  always_comb begin
    best_o = best_i;
    if (eligible && ticks_q > best_i.most) begin
      best_o.most = ticks_q;
      best_o.idx  = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= '0;
      sleep_q <= '0;
      wait_q  <= 1'b0;
    end else begin
      ticks_q <= ticks_d;
      sleep_q <= sleep_d;
      wait_q  <= wait_d;
    end
  end
endmodule
